[src/tmtsie_pkg.sv]
// ----------------------------------------------------------------------------
// TinyMT32 seed index enumerator package
// Shared widths, scheme constants, codes and the control bundle of the generator.
// ----------------------------------------------------------------------------
package tmtsie_pkg;

  // Field widths of one result.
  localparam int unsigned INDEX_WIDTH  = 24;
  localparam int unsigned SECOND_WIDTH = 25;
  localparam int unsigned SECVAL_WIDTH = 26;
  localparam int unsigned MAX_BATCH    = 64;

  // Result payload: index, random, four words, seed, second, exhausted.
  localparam int unsigned OUT_FIELD_W = INDEX_WIDTH + 6 * 32 + SECVAL_WIDTH + 1;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  // TinyMT32 parameters.
  localparam logic [31:0] MAT1       = 32'h8f70_11ee;
  localparam logic [31:0] MAT2       = 32'hfc78_ff1f;
  localparam logic [31:0] TMAT       = 32'h3793_fdff;
  localparam logic [31:0] LOW31      = 32'h7fff_ffff;
  localparam logic [31:0] INIT_MUL   = 32'd1812433253;
  localparam logic [31:0] SEED_SCALE = 32'd1000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODE,
    REG_STATE_LOW,
    REG_STATE_HIGH,
    REG_BASE_SEED,
    REG_FIRST,
    REG_LAST,
    REG_OFFSET,
    REG_COUNT
  } cfg_reg_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BAD_CFG,
    STAT_NOT_STARTED,
    STAT_EXHAUSTED
  } status_e;

  // Operations of the generator state unit.
  typedef enum logic [2:0] {
    GEN_HOLD,
    GEN_LOAD,
    GEN_SEED,
    GEN_XOR,
    GEN_FIX,
    GEN_NEXT
  } gen_op_e;

  // Control bundle from the sequencer to the generator.
  typedef struct packed {
    gen_op_e        op;
    logic [1:0]     sel;
    logic [127:0]   data;
  } gen_ctrl_t;

endpackage

[src/tmtsie_gen.sv]
// ----------------------------------------------------------------------------
// TinyMT32 generator state unit
// Holds the four state words and applies one operation per cycle: load,
// seed start, seed mixing xor, all-zero fix-up or one generator step.
// ----------------------------------------------------------------------------
module tmtsie_gen (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmtsie_pkg::gen_ctrl_t ctrl_i,
  output logic [3:0][31:0]      words_o,
  output logic [31:0]           temper_o
);
  import tmtsie_pkg::*;

  logic [3:0][31:0] s_q;
  logic [3:0][31:0] s_d;
  logic [3:0][31:0] step;
  logic [31:0]      x;
  logic [31:0]      y;
  logic [31:0]      t1;
  logic             all_zero;

  // One generator step.
  always_comb begin
    x = (s_q[0] & LOW31) ^ s_q[1] ^ s_q[2];
    x = x ^ (x << 1);
    y = s_q[3] ^ (s_q[3] >> 1) ^ x;
    step[0] = s_q[1];
    step[1] = s_q[2] ^ (y[0] ? MAT1 : 32'd0);
    step[2] = x ^ (y << 10) ^ (y[0] ? MAT2 : 32'd0);
    step[3] = y;
  end

  assign all_zero = ((s_q[0] & LOW31) == 32'd0) && (s_q[1] == 32'd0) &&
                    (s_q[2] == 32'd0) && (s_q[3] == 32'd0);

  // Next state for the requested operation.
  always_comb begin
    s_d = s_q;
    case (ctrl_i.op)
      GEN_LOAD: begin
        s_d = ctrl_i.data;
      end
      GEN_SEED: begin
        s_d[0] = ctrl_i.data[31:0];
        s_d[1] = MAT1;
        s_d[2] = MAT2;
        s_d[3] = TMAT;
      end
      GEN_XOR: begin
        s_d[ctrl_i.sel] = s_q[ctrl_i.sel] ^ ctrl_i.data[31:0];
      end
      GEN_FIX: begin
        if (all_zero) begin
          s_d[0] = 32'h0000_0054;
          s_d[1] = 32'h0000_0049;
          s_d[2] = 32'h0000_004e;
          s_d[3] = 32'h0000_0059;
        end
      end
      GEN_NEXT: begin
        s_d = step;
      end
      default: begin
        s_d = s_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else begin
      s_q <= s_d;
    end
  end

  // Tempered output of the current state.
  assign t1       = s_q[0] + (s_q[2] >> 8);
  assign temper_o = s_q[3] ^ t1 ^ (t1[0] ? TMAT : 32'd0);
  assign words_o  = s_q;

endmodule

[src/tinymt32_seed_index_enumerator_core.sv]
// ----------------------------------------------------------------------------
// TinyMT32 seed index enumerator core
// Validates the configuration, loads or seeds a TinyMT32 generator, skips to
// the first index and enumerates positions per second in batches.
//
//   Channel   Direction  Transaction
//   s_axis    in         tuser = restart, tdata = batch_size
//   m_axis    out        one result; tuser = status, tlast = last_of_run
//   cfg       in         register index and 64-bit write data
//
// A produce transaction emits one result per cycle from the emit state while
// the output side keeps up and no re-seed intervenes. A restart in mode 0
// loads the state and skips to the first index; in mode 1 it seeds from the
// second. A re-seed at a new second runs the single-step skip loop and the
// seven multiply/xor rounds of the shared multiplier. The output register
// frees the input once a result is held.
// Reset clears the generator, positions and configuration asynchronously.
// ----------------------------------------------------------------------------
module tinymt32_seed_index_enumerator_core #(
  parameter int unsigned MAX_BATCH = tmtsie_pkg::MAX_BATCH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [6:0] batch_size
  input  logic                              s_axis_tuser_i,  // [0] restart
  // Result items.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // index_value, random_value, word_zero..word_three, seed_value,
  // second_value, exhausted (lowest bit up)
  output logic [tmtsie_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]                        m_axis_tuser_o,  // [1:0] status
  output logic                              m_axis_tlast_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [63:0]                       cfg_data_i
);
  import tmtsie_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BATCH + 1);

  localparam logic [23:0] INDEX_LIMIT   = 24'd10000000;
  localparam logic [24:0] SECONDS_LIMIT = 25'd31622400;
  localparam logic [26:0] OFFSET_LIMIT  = 27'd60566400;
  localparam logic [63:0] TASK_LIMIT    = 64'd5000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_SEC,
    ST_SCALE,
    ST_BASE,
    ST_IMUL,
    ST_IXOR,
    ST_FIX,
    ST_SKIP,
    ST_EMIT,
    ST_RESP
  } state_e;

  // Configuration registers as written.
  logic                    r_mode_q;
  logic [63:0]             r_low_q;
  logic [63:0]             r_high_q;
  logic [31:0]             r_base_q;
  logic [23:0]             r_first_q;
  logic [23:0]             r_last_q;
  logic [25:0]             r_offset_q;
  logic [24:0]             r_count_q;

  // Configuration latched by a valid restart.
  logic                    l_mode_q;
  logic [31:0]             l_base_q;
  logic [23:0]             l_first_q;
  logic [23:0]             l_last_q;
  logic [25:0]             l_offset_q;
  logic [24:0]             l_count_q;

  // Sequencer state.
  state_e                  state_q;
  state_e                  post_q;
  status_e                 resp_q;
  logic                    started_q;
  logic [INDEX_WIDTH-1:0]  idx_q;
  logic [SECOND_WIDTH-1:0] pos_q;
  logic [23:0]             skip_q;
  logic [2:0]              round_q;
  logic [CNT_W-1:0]        remain_q;
  logic [SECVAL_WIDTH-1:0] sec_q;
  logic [31:0]             seed_q;
  logic [63:0]             prod_q;

  // Output register.
  logic                    o_valid_q;
  logic [INDEX_WIDTH-1:0]  o_idx_q;
  logic [31:0]             o_rand_q;
  logic [3:0][31:0]        o_words_q;
  logic [31:0]             o_seed_q;
  logic [SECVAL_WIDTH-1:0] o_sec_q;
  status_e                 o_status_q;
  logic                    o_exh_q;
  logic                    o_last_q;

  // Combinational helpers.
  logic                    in_fire;
  logic                    slot;
  logic                    out_load;
  logic [6:0]              batch;
  logic [CNT_W-1:0]        limit;
  logic                    done_now;
  logic [23:0]             span;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [31:0]             mix_p;
  logic                    cfg_bad;
  logic                    at_last;
  logic [SECOND_WIDTH:0]   pos_inc;
  logic                    final_sec;
  logic                    done_after;
  logic                    reseed;
  logic                    last_res;
  logic [31:0]             seed_sum;
  gen_ctrl_t               gen_ctrl;
  logic [3:0][31:0]        words;
  logic [31:0]             temper;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot            = !o_valid_q || m_axis_tready_i;
  assign batch           = s_axis_tdata_i[6:0];

  // A new result enters the output register this cycle.
  assign out_load = slot && ((state_q == ST_EMIT) || (state_q == ST_RESP));

  // Clamp the batch to the largest supported run.
  assign limit = (batch > 7'(MAX_BATCH)) ? CNT_W'(MAX_BATCH) : CNT_W'(batch);

  assign done_now = ({1'b0, pos_q} >= (l_mode_q ? {1'b0, l_count_q} : 26'd1));

  // Configuration check; the task count comes from the shared multiplier.
  assign span    = r_last_q - r_first_q + 24'd1;
  assign cfg_bad = (r_last_q > INDEX_LIMIT) || (r_first_q > r_last_q) ||
                   (r_count_q == 25'd0) || (r_count_q > SECONDS_LIMIT) ||
                   ({1'b0, r_offset_q} >= OFFSET_LIMIT) ||
                   ({1'b0, r_offset_q} + {2'b0, r_count_q} > OFFSET_LIMIT) ||
                   (prod_q > TASK_LIMIT);

  // Position bookkeeping for the result being emitted.
  assign at_last    = (idx_q == l_last_q);
  assign pos_inc    = {1'b0, pos_q} + 26'd1;
  assign final_sec  = !l_mode_q || (pos_inc >= {1'b0, l_count_q});
  assign done_after = at_last && final_sec;
  assign reseed     = at_last && !final_sec;
  assign last_res   = (remain_q == CNT_W'(1)) || done_after;

  assign mix_p    = words[2'(round_q - 3'd1)];
  assign seed_sum = l_base_q + prod_q[31:0];

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      ST_CHECK: begin
        mul_a = {8'd0, span};
        mul_b = r_mode_q ? {7'd0, r_count_q} : 32'd1;
      end
      ST_SCALE: begin
        mul_a = {6'd0, sec_q};
        mul_b = SEED_SCALE;
      end
      ST_IMUL: begin
        mul_a = INIT_MUL;
        mul_b = mix_p ^ (mix_p >> 30);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Generator operation for this cycle.
  always_comb begin
    gen_ctrl.op   = GEN_HOLD;
    gen_ctrl.sel  = round_q[1:0];
    gen_ctrl.data = {r_high_q, r_low_q};
    case (state_q)
      ST_DECIDE: begin
        if (!cfg_bad && !r_mode_q) begin
          gen_ctrl.op = GEN_LOAD;
        end
      end
      ST_BASE: begin
        gen_ctrl.op   = GEN_SEED;
        gen_ctrl.data = {96'd0, seed_sum};
      end
      ST_IXOR: begin
        gen_ctrl.op   = GEN_XOR;
        gen_ctrl.data = {96'd0, {29'd0, round_q} + prod_q[31:0]};
      end
      ST_FIX: begin
        gen_ctrl.op = GEN_FIX;
      end
      ST_SKIP: begin
        gen_ctrl.op = GEN_NEXT;
      end
      ST_EMIT: begin
        if (slot) begin
          gen_ctrl.op = GEN_NEXT;
        end
      end
      default: begin
        gen_ctrl.op = GEN_HOLD;
      end
    endcase
  end

  tmtsie_gen u_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (gen_ctrl),
    .words_o  (words),
    .temper_o (temper)
  );

  // Multiplier product register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_mode_q   <= 1'b0;
      r_low_q    <= '0;
      r_high_q   <= '0;
      r_base_q   <= '0;
      r_first_q  <= '0;
      r_last_q   <= '0;
      r_offset_q <= '0;
      r_count_q  <= 25'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODE:       r_mode_q   <= cfg_data_i[0];
        REG_STATE_LOW:  r_low_q    <= cfg_data_i;
        REG_STATE_HIGH: r_high_q   <= cfg_data_i;
        REG_BASE_SEED:  r_base_q   <= cfg_data_i[31:0];
        REG_FIRST:      r_first_q  <= cfg_data_i[23:0];
        REG_LAST:       r_last_q   <= cfg_data_i[23:0];
        REG_OFFSET:     r_offset_q <= cfg_data_i[25:0];
        REG_COUNT:      r_count_q  <= cfg_data_i[24:0];
        default: begin
          r_mode_q <= r_mode_q;
        end
      endcase
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      post_q     <= ST_IDLE;
      resp_q     <= STAT_OK;
      started_q  <= 1'b0;
      idx_q      <= '0;
      pos_q      <= '0;
      skip_q     <= '0;
      round_q    <= 3'd1;
      remain_q   <= '0;
      sec_q      <= '0;
      seed_q     <= '0;
      l_mode_q   <= 1'b0;
      l_base_q   <= '0;
      l_first_q  <= '0;
      l_last_q   <= '0;
      l_offset_q <= '0;
      l_count_q  <= 25'd1;
      o_valid_q  <= 1'b0;
      o_idx_q    <= '0;
      o_rand_q   <= '0;
      o_words_q  <= '0;
      o_seed_q   <= '0;
      o_sec_q    <= '0;
      o_status_q <= STAT_OK;
      o_exh_q    <= 1'b0;
      o_last_q   <= 1'b0;
    end else begin
      // The output transaction completes and nothing new replaces it.
      if (o_valid_q && m_axis_tready_i && !out_load) begin
        o_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser_i) begin
              started_q <= 1'b0;
              state_q   <= ST_CHECK;
            end else if (!started_q) begin
              resp_q  <= STAT_NOT_STARTED;
              state_q <= ST_RESP;
            end else if (done_now) begin
              resp_q  <= STAT_EXHAUSTED;
              state_q <= ST_RESP;
            end else if (limit != '0) begin
              remain_q <= limit;
              state_q  <= ST_EMIT;
            end
          end
        end

        ST_CHECK: begin
          state_q <= ST_DECIDE;
        end

        ST_DECIDE: begin
          if (cfg_bad) begin
            resp_q  <= STAT_BAD_CFG;
            state_q <= ST_RESP;
          end else begin
            l_mode_q   <= r_mode_q;
            l_base_q   <= r_base_q;
            l_first_q  <= r_first_q;
            l_last_q   <= r_last_q;
            l_offset_q <= r_offset_q;
            l_count_q  <= r_count_q;
            pos_q      <= '0;
            idx_q      <= INDEX_WIDTH'(r_first_q);
            started_q  <= 1'b1;
            resp_q     <= STAT_OK;
            post_q     <= ST_RESP;
            if (r_mode_q) begin
              state_q <= ST_SEC;
            end else begin
              skip_q  <= r_first_q + 24'd1;
              state_q <= ST_SKIP;
            end
          end
        end

        // Seed start: second, scaled second, then seed word.
        ST_SEC: begin
          sec_q   <= l_offset_q + {1'b0, pos_q};
          state_q <= ST_SCALE;
        end

        ST_SCALE: begin
          state_q <= ST_BASE;
        end

        ST_BASE: begin
          seed_q  <= seed_sum;
          round_q <= 3'd1;
          state_q <= ST_IMUL;
        end

        // Seven mixing rounds through the shared multiplier.
        ST_IMUL: begin
          state_q <= ST_IXOR;
        end

        ST_IXOR: begin
          if (round_q == 3'd7) begin
            state_q <= ST_FIX;
          end else begin
            round_q <= round_q + 3'd1;
            state_q <= ST_IMUL;
          end
        end

        // Eight warm-up steps plus the skip to the first index.
        ST_FIX: begin
          skip_q  <= l_first_q + 24'd9;
          state_q <= ST_SKIP;
        end

        ST_SKIP: begin
          skip_q <= skip_q - 24'd1;
          if (skip_q == 24'd1) begin
            state_q <= post_q;
          end
        end

        ST_EMIT: begin
          if (slot) begin
            o_valid_q  <= 1'b1;
            o_idx_q    <= idx_q;
            o_rand_q   <= temper;
            o_words_q  <= words;
            o_seed_q   <= l_mode_q ? seed_q : 32'd0;
            o_sec_q    <= l_mode_q ? sec_q : '0;
            o_status_q <= STAT_OK;
            o_exh_q    <= done_after;
            o_last_q   <= last_res;
            remain_q   <= remain_q - CNT_W'(1);
            if (at_last) begin
              if (final_sec) begin
                pos_q <= l_mode_q ? l_count_q : SECOND_WIDTH'(1);
              end else begin
                pos_q <= pos_inc[SECOND_WIDTH-1:0];
                idx_q <= INDEX_WIDTH'(l_first_q);
              end
            end else begin
              idx_q <= idx_q + INDEX_WIDTH'(1);
            end
            if (reseed) begin
              post_q  <= last_res ? ST_IDLE : ST_EMIT;
              state_q <= ST_SEC;
            end else if (last_res) begin
              state_q <= ST_IDLE;
            end
          end
        end

        // Single status result for restarts and refused produce items.
        ST_RESP: begin
          if (slot) begin
            o_valid_q  <= 1'b1;
            o_idx_q    <= '0;
            o_rand_q   <= '0;
            o_words_q  <= '0;
            o_seed_q   <= '0;
            o_sec_q    <= '0;
            o_status_q <= resp_q;
            o_exh_q    <= (resp_q != STAT_OK);
            o_last_q   <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, o_exh_q, o_sec_q, o_seed_q,
                            o_words_q[3], o_words_q[2], o_words_q[1], o_words_q[0],
                            o_rand_q, o_idx_q};
  assign m_axis_tuser_o  = o_status_q;
  assign m_axis_tlast_o  = o_last_q;

endmodule
